FILE: design/mvtc_pkg.sv
// ----------------------------------------------------------------------------
// mvtc_pkg
// shared constants, codes and control types of the multi valve timeout
// controller
// ----------------------------------------------------------------------------
package mvtc_pkg;

    // sizing
    localparam int VALVES     = 8;
    localparam int VIDX_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int MAX_OPEN   = 3600;
    localparam int MS_PER_S   = 1000;
    localparam int EFF_W      = $clog2(MAX_OPEN + 1);
    localparam int MS_W       = $clog2(MAX_OPEN * MS_PER_S + 1);

    // port widths
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [2:0] OP_OPEN        = 3'd0;
    localparam logic [2:0] OP_CLOSE       = 3'd1;
    localparam logic [2:0] OP_CLOSE_ALL   = 3'd2;
    localparam logic [2:0] OP_FORCE_CLOSE = 3'd3;
    localparam logic [2:0] OP_TICK        = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ID    = 2'd1;
    localparam logic [1:0] ST_ZERO_DUR  = 2'd2;
    localparam logic [1:0] ST_BATT_LOW  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VALVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_LOCK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OPEN    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_EMIT
    } mvtc_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic emit;
    } mvtc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic scan_done;
        logic slot_free;
        logic multi;
    } mvtc_sts_t;

endpackage

FILE: design/mvtc_ctrl.sv
// ----------------------------------------------------------------------------
// mvtc_ctrl
// sequencer: takes one command, prepares it, runs the deadline scan for a
// tick and then hands out one result per pulse
// ----------------------------------------------------------------------------
module mvtc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mvtc_pkg::mvtc_sts_t sts,
    output mvtc_pkg::mvtc_cmd_t cmd
);
    import mvtc_pkg::*;

    mvtc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.is_tick ? S_SCAN : S_EMIT;
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    if (!sts.multi) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/mvtc_datapath.sv
// ----------------------------------------------------------------------------
// mvtc_datapath
// valve flags, deadline store, configuration registers, pulse mask and the
// output register
// ----------------------------------------------------------------------------
module mvtc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [mvtc_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mvtc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    input  logic [mvtc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvtc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  mvtc_pkg::mvtc_cmd_t                  cmd,
    output mvtc_pkg::mvtc_sts_t                  sts
);
    import mvtc_pkg::*;

    // captured item
    logic [2:0]          op_reg;
    logic [7:0]          id_reg;
    logic [31:0]         dur_reg;
    logic [31:0]         now_reg;

    // configuration
    logic [COUNT_W-1:0]  count_reg;
    logic                lock_reg;
    logic [15:0]         max_cfg_reg;

    // valve state
    logic [VALVES-1:0]   open_reg;
    logic [31:0]         deadline_mem [VALVES];

    // per item work
    logic [EFF_W-1:0]    eff_reg;
    logic [1:0]          status_reg;
    logic [VALVES-1:0]   mask_reg;

    // scan pipeline
    logic [VIDX_W-1:0]   scan_cnt_reg;
    logic                scan_run_reg;
    logic                chk_vld_reg;
    logic [VIDX_W-1:0]   chk_idx_reg;
    logic                chk_open_reg;
    logic [31:0]         dl_rd_reg;

    // output register
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic [COUNT_W-1:0]  n_act;
    logic [VALVES-1:0]   active;
    logic                id_ok;
    logic [VALVES-1:0]   id_oh;
    logic [31:0]         lim32;
    logic [EFF_W-1:0]    eff_c;
    logic [1:0]          st_c;
    logic [VALVES-1:0]   mask_c;
    logic [VALVES-1:0]   sel_oh;
    logic [VIDX_W-1:0]   sel_idx;
    logic                mask_any;
    logic [VALVES-1:0]   open_next;
    logic [MS_W-1:0]     ms_c;
    logic [31:0]         diff_c;
    logic [COUNT_W-1:0]  new_n;
    logic [COUNT_W-1:0]  clr_from;

    assign n_act = (count_reg > COUNT_W'(VALVES)) ? COUNT_W'(VALVES) : count_reg;

    always_comb begin
        for (int i = 0; i < VALVES; i++) begin
            active[i] = (COUNT_W'(i) < n_act);
        end
    end

    // open / close preparation
    assign id_ok = (id_reg < {{(8-COUNT_W){1'b0}}, n_act});
    assign id_oh = VALVES'(1) << id_reg[VIDX_W-1:0];

    always_comb begin
        if ((max_cfg_reg != 16'd0) && ({16'd0, max_cfg_reg} < dur_reg)) begin
            lim32 = {16'd0, max_cfg_reg};
        end else begin
            lim32 = dur_reg;
        end
        if (lim32 > 32'(MAX_OPEN)) begin
            eff_c = EFF_W'(MAX_OPEN);
        end else begin
            eff_c = lim32[EFF_W-1:0];
        end
    end

    always_comb begin
        st_c   = ST_OK;
        mask_c = '0;
        case (op_reg)
            OP_OPEN: begin
                if (!id_ok) begin
                    st_c = ST_BAD_ID;
                end else if (dur_reg == 32'd0) begin
                    st_c = ST_ZERO_DUR;
                end else if (lock_reg) begin
                    st_c = ST_BATT_LOW;
                end else if (!open_reg[id_reg[VIDX_W-1:0]]) begin
                    mask_c = id_oh;
                end
            end
            OP_CLOSE: begin
                if (!id_ok) begin
                    st_c = ST_BAD_ID;
                end else if (open_reg[id_reg[VIDX_W-1:0]]) begin
                    mask_c = id_oh;
                end
            end
            OP_CLOSE_ALL:   mask_c = open_reg & active;
            OP_FORCE_CLOSE: mask_c = active;
            default:        mask_c = '0;
        endcase
    end

    // lowest pending valve
    assign mask_any = (mask_reg != '0);
    assign sel_oh   = mask_reg & (~mask_reg + VALVES'(1));

    always_comb begin
        sel_idx = '0;
        for (int i = VALVES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_idx = VIDX_W'(i);
            end
        end
    end

    always_comb begin
        if (!mask_any) begin
            open_next = open_reg;
        end else if (op_reg == OP_OPEN) begin
            open_next = open_reg | sel_oh;
        end else begin
            open_next = open_reg & ~sel_oh;
        end
    end

    assign ms_c   = MS_W'(eff_reg) * MS_W'(MS_PER_S);
    assign diff_c = now_reg - dl_rd_reg;

    assign new_n    = (cfg_data[COUNT_W-1:0] > COUNT_W'(VALVES)) ?
                      COUNT_W'(VALVES) : cfg_data[COUNT_W-1:0];
    assign clr_from = (new_n < n_act) ? new_n : n_act;

    // payload capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_tdata[2:0];
            id_reg  <= s_tdata[10:3];
            dur_reg <= s_tdata[42:11];
            now_reg <= s_tdata[74:43];
        end
        if (cmd.prep) begin
            eff_reg    <= eff_c;
            status_reg <= st_c;
        end
    end

    // configuration and valve flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            lock_reg    <= 1'b0;
            max_cfg_reg <= '0;
            open_reg    <= '0;
        end else begin
            if (cmd.emit) begin
                open_reg <= open_next;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_VALVE_COUNT: begin
                        count_reg <= cfg_data[COUNT_W-1:0];
                        for (int i = 0; i < VALVES; i++) begin
                            if (COUNT_W'(i) >= clr_from) begin
                                open_reg[i] <= 1'b0;
                            end
                        end
                    end
                    REG_BATT_LOCK: lock_reg    <= cfg_data[0];
                    REG_MAX_OPEN:  max_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // deadline store
    always_ff @(posedge aclk) begin
        if (cmd.emit && (op_reg == OP_OPEN) && (status_reg == ST_OK)) begin
            deadline_mem[id_reg[VIDX_W-1:0]] <= now_reg + 32'(ms_c);
        end
        if (scan_run_reg) begin
            dl_rd_reg <= deadline_mem[scan_cnt_reg];
        end
    end

    // tick scan and pending mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_run_reg <= 1'b0;
            scan_cnt_reg <= '0;
            chk_vld_reg  <= 1'b0;
            mask_reg     <= '0;
        end else begin
            chk_vld_reg <= scan_run_reg;
            if (scan_run_reg) begin
                chk_idx_reg  <= scan_cnt_reg;
                chk_open_reg <= open_reg[scan_cnt_reg] & active[scan_cnt_reg];
                scan_cnt_reg <= scan_cnt_reg + VIDX_W'(1);
                if (scan_cnt_reg == VIDX_W'(VALVES - 1)) begin
                    scan_run_reg <= 1'b0;
                end
            end
            if (chk_vld_reg && chk_open_reg && !diff_c[31]) begin
                mask_reg[chk_idx_reg] <= 1'b1;
            end
            if (cmd.prep) begin
                mask_reg <= mask_c;
                if (op_reg == OP_TICK) begin
                    scan_run_reg <= 1'b1;
                    scan_cnt_reg <= '0;
                end
            end else if (cmd.emit) begin
                mask_reg <= mask_reg & ~sel_oh;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (mask_any) begin
                out_data_reg <= {1'b0, open_next & active, (op_reg == OP_OPEN),
                                 sel_idx, 1'b1, ST_OK};
                out_last_reg <= ((mask_reg & ~sel_oh) == '0);
            end else begin
                out_data_reg <= {1'b0, open_reg & active, 1'b0, {VIDX_W{1'b0}},
                                 1'b0, status_reg};
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign sts.is_tick   = (op_reg == OP_TICK);
    assign sts.scan_done = chk_vld_reg && (chk_idx_reg == VIDX_W'(VALVES - 1));
    assign sts.slot_free = !out_valid_reg || m_tready;
    assign sts.multi     = ((mask_reg & (mask_reg - VALVES'(1))) != '0);

endmodule

FILE: design/multi_valve_timeout_controller.sv
// ----------------------------------------------------------------------------
// multi_valve_timeout_controller
// open flags and millisecond close deadlines for up to eight valves
// ----------------------------------------------------------------------------
// usage
//  - s_ channel takes one command per transfer: open, close, close all,
//    force close all or tick, with valve id, duration and current time
//  - m_ channel returns one result per driver pulse, lowest valve first;
//    a command without a pulse returns one result carrying its status;
//    m_tlast marks the final result of a command
//  - cfg channel writes valve count, battery lockout and the open time limit;
//    cfg_ready is always high, write only while the block is idle
//  - the first result is registered after the input transfer; a tick first runs
//    its deadline scan, which reads the deadline store one valve per cycle over
//    all eight entries
//  - one command at a time; a tick adds its deadline scan before its results;
//    further results follow one per cycle while m_tready stays high
//  - s_tready is high only while the sequencer waits for a command; it may
//    take the next command while the last result still sits in m_tdata
//  - a stalled receiver holds the output register and the sequencer waits
//  - reset clears the configuration, all open flags and the sequencer
// ----------------------------------------------------------------------------
module multi_valve_timeout_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: command[2:0], valve_id[10:3], duration_seconds[42:11],
    //          now_ms[74:43], zero fill[79:75]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mvtc_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: status[1:0], pulse_valid[2], pulse_valve[5:3], pulse_open[6],
    //          open_bitmap[14:7], zero fill[15]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mvtc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mvtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvtc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mvtc_pkg::*;

    mvtc_cmd_t cmd;
    mvtc_sts_t sts;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencer
    mvtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // flags, deadlines, mask and output register
    mvtc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one command in flight: no new transfer right after one was taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in flight");

    // a result without a pulse always closes its command
    a_nopulse_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> m_tlast)
        else $error("pulse-free result not marked last");

    // an open pulse shows its valve open in the bitmap
    a_open_in_bitmap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2] && m_tdata[6]) |->
        (((m_tdata[14:7] >> m_tdata[5:3]) & 8'd1) != 8'd0))
        else $error("open pulse without bitmap bit");

    // open pulse only as a real pulse
    a_open_is_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6]) |-> m_tdata[2])
        else $error("open flag on pulse-free result");

endmodule
